@@ design/slsc_pkg.sv @@
// Package for the seeded list shuffle and slot lookup core.
// Holds beat types, sizes, item kinds, the mixing constant and the state encoding.
// No dependencies.
package slsc_pkg;

    localparam int MAX_MEMBERS = 64;
    localparam int IDX_W       = $clog2(MAX_MEMBERS);
    localparam int CNT_W       = $clog2(MAX_MEMBERS + 1);
    localparam int OUT_CNT_W   = 7;

    localparam logic [63:0] MIX_MULT = 64'd2685821657736338717;

    localparam logic [1:0] KIND_LOAD   = 2'd0;
    localparam logic [1:0] KIND_BLOCK  = 2'd1;
    localparam logic [1:0] KIND_LOOKUP = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] member_id;
        logic        restart_list;
        logic [31:0] block_number;
        logic [31:0] block_time;
        logic [63:0] abs_slot;
    } t_in_beat;

    typedef struct packed {
        logic [31:0] slot_member;
        logic        found;
        logic        reshuffled;
        logic        dropped;
        logic [6:0]  list_count;
    } t_out_beat;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BMOD,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_MIX,
        ST_MULT,
        ST_MUL2,
        ST_MUL3,
        ST_KMOD,
        ST_SW_RD,
        ST_SW_WR,
        ST_LMOD,
        ST_LRD,
        ST_LOUT,
        ST_OUT
    } t_state;

endpackage

@@ design/slsc_divider.sv @@
// Restoring divider for the core: 64-bit dividend modulo a count, one bit per cycle.
// Uses slsc_pkg for the count width.
module slsc_divider (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [63:0]             i_dividend,
    input  logic [slsc_pkg::CNT_W-1:0] i_divisor,
    output logic                    o_done,
    output logic [slsc_pkg::CNT_W-1:0] o_rem
);
    import slsc_pkg::*;

    logic [63:0]      r_quo;
    logic [CNT_W:0]   r_rem;
    logic [CNT_W-1:0] r_div;
    logic [6:0]       r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [CNT_W:0]   n_shift;

    assign n_shift = {r_rem[CNT_W-1:0], r_quo[63]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[62:0], 1'b0};
            if (n_shift >= {1'b0, r_div}) begin
                r_rem <= n_shift - {1'b0, r_div};
            end else begin
                r_rem <= n_shift;
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[CNT_W-1:0];

endmodule

@@ design/seeded_list_shuffle_and_slot_lookup_core.sv @@
// Channel | direction | payload
// in      | i_in_*    | t_in_beat: kind, member id, restart, block number, time, slot
// out     | o_out_*   | t_out_beat: member, found, reshuffled, dropped, list count
// A load, an empty lookup or an unused kind goes straight to the result; a lookup
// reduces its slot in the modulo unit. A block event reduces its block number and,
// on zero, reshuffles: copy each entry, then mix, multiply, reduce and swap each.
// One item is worked at a time; the next is taken once the result register is
// free or being taken. Reset empties both lists; the stores hold no reset value.
// Top level. Uses slsc_pkg and slsc_divider.
module seeded_list_shuffle_and_slot_lookup_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  slsc_pkg::t_in_beat  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output slsc_pkg::t_out_beat o_out_data
);
    import slsc_pkg::*;

    logic [31:0] active_mem [MAX_MEMBERS];
    logic [31:0] shuf_mem   [MAX_MEMBERS];

    t_state           r_state, n_state;
    t_in_beat         r_item;
    logic [CNT_W-1:0] r_acount, r_scount, r_n, r_i;
    logic [IDX_W-1:0] r_j;
    logic [31:0]      r_arddata, r_srddata;
    logic [63:0]      r_k, r_prod;
    logic             r_ovalid;
    t_out_beat        r_odata;

    logic             div_start, div_done;
    logic [63:0]      div_dvd;
    logic [CNT_W-1:0] div_dsr, div_rem;

    logic             a_we, s_we;
    logic [IDX_W-1:0] a_waddr, a_raddr, s_waddr, s_raddr;
    logic [31:0]      a_wdata, s_wdata;

    logic             accept, out_free, load_full;
    logic [63:0]      k0, k1, k2, k3;
    logic [CNT_W:0]   jsum;
    logic [31:0]      mul_a, mul_b;
    logic [63:0]      mul_p;

    slsc_divider u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_dividend(div_dvd),
        .i_divisor (div_dsr),
        .o_done    (div_done),
        .o_rem     (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (a_we) begin
            active_mem[a_waddr] <= a_wdata;
        end
        r_arddata <= active_mem[a_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (s_we) begin
            shuf_mem[s_waddr] <= s_wdata;
        end
        r_srddata <= shuf_mem[s_raddr];
    end

    assign out_free   = !r_ovalid || !i_out_stall;
    assign o_in_stall = !(r_state == ST_IDLE && out_free);
    assign accept     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;
    assign load_full  = (i_in_data.kind == KIND_LOAD) && !i_in_data.restart_list &&
                        (r_acount >= CNT_W'(MAX_MEMBERS));

    assign k0 = {r_item.block_time, 32'd0} + 64'(r_i) * MIX_MULT;
    assign k1 = k0 ^ (k0 >> 12);
    assign k2 = k1 ^ (k1 << 25);
    assign k3 = k2 ^ (k2 >> 27);
    assign jsum = {1'b0, r_i} + {1'b0, div_rem};
    assign mul_p = 64'(mul_a) * 64'(mul_b);

    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        div_dvd   = r_k;
        div_dsr   = r_n - r_i;
        a_we      = 1'b0;
        a_waddr   = r_acount[IDX_W-1:0];
        a_wdata   = i_in_data.member_id;
        a_raddr   = r_i[IDX_W-1:0];
        s_we      = 1'b0;
        s_waddr   = r_i[IDX_W-1:0];
        s_wdata   = r_arddata;
        s_raddr   = r_i[IDX_W-1:0];
        mul_a     = r_k[31:0];
        mul_b     = MIX_MULT[31:0];
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_in_data.kind)
                        KIND_LOAD: begin
                            n_state = ST_OUT;
                            if (i_in_data.restart_list) begin
                                a_we = 1'b1;
                                a_waddr = '0;
                            end else if (r_acount < CNT_W'(MAX_MEMBERS)) begin
                                a_we = 1'b1;
                            end
                        end
                        KIND_BLOCK: begin
                            if (r_acount != '0) begin
                                n_state   = ST_BMOD;
                                div_start = 1'b1;
                                div_dvd   = {32'd0, i_in_data.block_number};
                                div_dsr   = r_acount;
                            end else begin
                                n_state = ST_OUT;
                            end
                        end
                        KIND_LOOKUP: begin
                            if (r_scount != '0) begin
                                n_state   = ST_LMOD;
                                div_start = 1'b1;
                                div_dvd   = i_in_data.abs_slot;
                                div_dsr   = r_scount;
                            end else begin
                                n_state = ST_OUT;
                            end
                        end
                        default: n_state = ST_OUT;
                    endcase
                end
            end
            ST_BMOD: begin
                if (div_done) begin
                    n_state = (div_rem == '0) ? ST_COPY_RD : ST_OUT;
                end
            end
            ST_COPY_RD: n_state = ST_COPY_WR;
            ST_COPY_WR: begin
                s_we = 1'b1;
                n_state = (r_i == r_n - CNT_W'(1)) ? ST_MIX : ST_COPY_RD;
            end
            ST_MIX:  n_state = ST_MULT;
            ST_MULT: n_state = ST_MUL2;
            ST_MUL2: begin
                n_state = ST_MUL3;
                mul_b   = MIX_MULT[63:32];
            end
            ST_MUL3: begin
                n_state   = ST_KMOD;
                mul_a     = r_k[63:32];
                div_start = 1'b1;
                div_dvd   = r_prod + {mul_p[31:0], 32'd0};
            end
            ST_KMOD: begin
                if (div_done) begin
                    n_state = ST_SW_RD;
                end
                s_raddr = jsum[IDX_W-1:0];
            end
            ST_SW_RD: begin
                n_state = ST_SW_WR;
                s_we    = 1'b1;
                s_waddr = r_i[IDX_W-1:0];
                s_wdata = r_srddata;
                s_raddr = r_i[IDX_W-1:0];
            end
            ST_SW_WR: begin
                s_we    = 1'b1;
                s_waddr = r_j;
                s_wdata = r_srddata;
                n_state = (r_i == r_n - CNT_W'(1)) ? ST_OUT : ST_MIX;
            end
            ST_LMOD: begin
                if (div_done) begin
                    n_state = ST_LRD;
                end
                s_raddr = div_rem[IDX_W-1:0];
            end
            ST_LRD: begin
                n_state = ST_LOUT;
                s_raddr = div_rem[IDX_W-1:0];
            end
            ST_LOUT: n_state = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_acount <= '0;
            r_scount <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_OUT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_item <= i_in_data;
                        r_odata <= {32'd0, 1'b0, 1'b0, load_full, 7'd0};
                        r_i <= '0;
                        r_n <= r_acount;
                        if (i_in_data.kind == KIND_LOAD) begin
                            if (i_in_data.restart_list) begin
                                r_acount <= CNT_W'(1);
                            end else if (r_acount < CNT_W'(MAX_MEMBERS)) begin
                                r_acount <= r_acount + CNT_W'(1);
                            end
                        end
                    end
                end
                ST_BMOD: begin
                    if (div_done && div_rem == '0) begin
                        r_scount <= r_n;
                        r_odata.reshuffled <= 1'b1;
                    end
                end
                ST_COPY_WR: begin
                    r_i <= (r_i == r_n - CNT_W'(1)) ? '0 : r_i + CNT_W'(1);
                end
                ST_MIX: r_k <= k3;
                ST_MULT: r_prod <= mul_p;
                ST_MUL2: r_prod <= r_prod + {mul_p[31:0], 32'd0};
                ST_KMOD: begin
                    if (div_done) begin
                        r_j <= jsum[IDX_W-1:0];
                    end
                end
                ST_SW_WR: begin
                    r_i <= r_i + CNT_W'(1);
                end
                ST_LOUT: begin
                    r_odata <= {r_srddata, 1'b1, 1'b0, 1'b0, 7'd0};
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_odata.list_count <= OUT_CNT_W'(r_acount);
                    end
                end
                default: ;
            endcase
        end
    end

endmodule
